### sv/lesf_pkg.sv
// Shared types, widths and register codes for the largest empty square finder.
// No dependencies; every other file of the block refers to this package by scope.
package lesf_pkg;

    // Fixed field widths of the item and result formats
    localparam int CHAR_W    = 8;
    localparam int DIM_W     = 11;
    localparam int SIZE_W    = 11;
    localparam int ROW_OUT_W = 10;
    localparam int COL_OUT_W = 10;

    // Default grid capacity
    localparam int DEF_MAX_COLS = 1024;
    localparam int DEF_MAX_ROWS = 1024;

    // Configuration port
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    // Register reset values
    localparam logic [DIM_W-1:0]  GRID_COLS_RST = 11'd1;
    localparam logic [DIM_W-1:0]  GRID_ROWS_RST = 11'd1;
    localparam logic [CHAR_W-1:0] OBSTACLE_RST  = 8'd111;

    // Register index, taken from paddr[3:2]
    typedef enum logic [1:0] {
        REG_GRID_COLS = 2'd0,
        REG_GRID_ROWS = 2'd1,
        REG_OBSTACLE  = 2'd2
    } lesf_reg_idx_t;

    // Current configuration handed to the datapath
    typedef struct packed {
        logic [DIM_W-1:0]  grid_cols;
        logic [DIM_W-1:0]  grid_rows;
        logic [CHAR_W-1:0] obstacle_char;
    } lesf_cfg_t;

endpackage

### sv/largest_empty_square_finder.sv
// Top level of the largest empty square finder: cell counters, score stage, wiring.
// Depends on lesf_pkg, lesf_cfg_regs, lesf_score_ram and lesf_result.
//
//  Port group   Dir  Contents
//  s_*          in   one grid cell per item, cell_char in s_tdata[7:0]
//  m_*          out  one result per grid: square_size, bottom_row, right_col
//  p*           in   APB register bank: grid_cols 0x0, grid_rows 0x4, obstacle_char 0x8
//
// One cell per cycle sustained while s_tready is high; the score row memory is read
// when a cell is taken and written when it leaves stage 1, with same-entry bypass
// for one-column grids. A grid's result passes stage 1, then the output register.
// aresetn (synchronous) clears counters, best square and left/diagonal scores;
// the score memory is not cleared. s_tready drops only while the last cell of a
// grid waits for an earlier result that m_tready has not yet taken.
module largest_empty_square_finder #(
    parameter int MAX_COLS = lesf_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = lesf_pkg::DEF_MAX_ROWS
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // s_tdata: cell_char [7:0]
    input  logic [7:0]                       s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // m_tdata: square_size [10:0], bottom_row [20:11], right_col [30:21], zero [31]
    output logic [31:0]                      m_tdata,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [lesf_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [lesf_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [lesf_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int DIM_W   = lesf_pkg::DIM_W;
    localparam int COL_AW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
    localparam int ROW_AW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int SCORE_W = $clog2(MAX_COLS + 1);
    localparam int CCMP_W  = (COL_AW + 1 > DIM_W) ? COL_AW + 1 : DIM_W;
    localparam int RCMP_W  = (ROW_AW + 1 > DIM_W) ? ROW_AW + 1 : DIM_W;

    lesf_pkg::lesf_cfg_t cfg;

    logic [COL_AW-1:0]  col_count_reg;
    logic [ROW_AW-1:0]  row_count_reg;
    logic [CCMP_W-1:0]  cols_eff;
    logic [RCMP_W-1:0]  rows_eff;
    logic               last_col;
    logic               last_row;
    logic               in_end;
    logic               s_acc;

    logic               s1_valid_reg;
    logic               s1_obst_reg;
    logic               s1_edge_reg;
    logic               s1_end_reg;
    logic [ROW_AW-1:0]  s1_row_reg;
    logic [COL_AW-1:0]  s1_col_reg;
    logic               s1_adv;
    logic               s1_block;

    logic [SCORE_W-1:0] up_score;
    logic [SCORE_W-1:0] left_score_reg;
    logic [SCORE_W-1:0] diag_score_reg;
    logic [SCORE_W-1:0] min_lu;
    logic [SCORE_W-1:0] min_all;
    logic [SCORE_W-1:0] score;

    lesf_cfg_regs u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Grid dimensions clamped to 1..MAX
    always_comb begin
        if (cfg.grid_cols == '0) begin
            cols_eff = CCMP_W'(1);
        end else if (CCMP_W'(cfg.grid_cols) > CCMP_W'(MAX_COLS)) begin
            cols_eff = CCMP_W'(MAX_COLS);
        end else begin
            cols_eff = CCMP_W'(cfg.grid_cols);
        end
        if (cfg.grid_rows == '0) begin
            rows_eff = RCMP_W'(1);
        end else if (RCMP_W'(cfg.grid_rows) > RCMP_W'(MAX_ROWS)) begin
            rows_eff = RCMP_W'(MAX_ROWS);
        end else begin
            rows_eff = RCMP_W'(cfg.grid_rows);
        end
    end

    assign last_col = (CCMP_W'(col_count_reg) + CCMP_W'(1)) >= cols_eff;
    assign last_row = (RCMP_W'(row_count_reg) + RCMP_W'(1)) >= rows_eff;
    assign in_end   = last_col && last_row;

    // Handshake: stage 1 frees up whenever it advances or is empty
    assign s1_adv   = s1_valid_reg && !s1_block;
    assign s_tready = !(s1_valid_reg && s1_block);
    assign s_acc    = s_tvalid && s_tready;

    // Cell position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_count_reg <= '0;
            row_count_reg <= '0;
        end else if (s_acc) begin
            if (in_end) begin
                col_count_reg <= '0;
                row_count_reg <= '0;
            end else if (last_col) begin
                col_count_reg <= '0;
                row_count_reg <= row_count_reg + ROW_AW'(1);
            end else begin
                col_count_reg <= col_count_reg + COL_AW'(1);
            end
        end
    end

    // Stage 1 holds the cell while the row above is read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_acc) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_adv) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            s1_obst_reg <= (s_tdata == cfg.obstacle_char);
            s1_edge_reg <= (row_count_reg == '0) || (col_count_reg == '0);
            s1_end_reg  <= in_end;
            s1_row_reg  <= row_count_reg;
            s1_col_reg  <= col_count_reg;
        end
    end

    lesf_score_ram #(
        .DEPTH (MAX_COLS),
        .AW    (COL_AW),
        .DW    (SCORE_W)
    ) u_ram (
        .aclk    (aclk),
        .rd_en   (s_acc),
        .rd_addr (col_count_reg),
        .wr_en   (s1_adv),
        .wr_addr (s1_col_reg),
        .wr_data (score),
        .rd_data (up_score)
    );

    // Score: 0 for an obstacle, 1 on the first row or column, else 1 + min of neighbours
    assign min_lu  = (left_score_reg < up_score) ? left_score_reg : up_score;
    assign min_all = (min_lu < diag_score_reg) ? min_lu : diag_score_reg;

    always_comb begin
        if (s1_obst_reg) begin
            score = '0;
        end else if (s1_edge_reg) begin
            score = SCORE_W'(1);
        end else begin
            score = min_all + SCORE_W'(1);
        end
    end

    // Left and diagonal neighbours follow the cell order
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_score_reg <= '0;
            diag_score_reg <= '0;
        end else if (s1_adv) begin
            if (s1_end_reg) begin
                left_score_reg <= '0;
                diag_score_reg <= '0;
            end else begin
                left_score_reg <= score;
                diag_score_reg <= up_score;
            end
        end
    end

    lesf_result #(
        .SCORE_W (SCORE_W),
        .ROW_AW  (ROW_AW),
        .COL_AW  (COL_AW)
    ) u_result (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .adv      (s1_adv),
        .end_cell (s1_end_reg),
        .score    (score),
        .row      (s1_row_reg),
        .col      (s1_col_reg),
        .block    (s1_block),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

`ifndef SYNTH
    // Same-entry read and write in one cycle must see the fresh score
    a_bypass: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && s1_adv && (col_count_reg == s1_col_reg) |=> up_score == $past(score))
        else $error("score bypass missed");

    // Counters restart after the last cell of a grid
    a_grid_wrap: assert property (@(posedge aclk) disable iff (!aresetn)
        s_acc && in_end |=> (col_count_reg == '0) && (row_count_reg == '0))
        else $error("counters not cleared at grid end");
`endif

endmodule

### sv/lesf_cfg_regs.sv
// APB register bank: grid width, grid height and obstacle character.
// Depends on lesf_pkg for the register codes and the configuration struct.
module lesf_cfg_regs (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [lesf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [lesf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [lesf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    output lesf_pkg::lesf_cfg_t                 cfg
);

    localparam int DIM_W  = lesf_pkg::DIM_W;
    localparam int CHAR_W = lesf_pkg::CHAR_W;
    localparam int DATA_W = lesf_pkg::APB_DATA_W;

    logic [DIM_W-1:0]         grid_cols_reg;
    logic [DIM_W-1:0]         grid_rows_reg;
    logic [CHAR_W-1:0]        obstacle_reg;
    logic                     wr_en;
    lesf_pkg::lesf_reg_idx_t  reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = lesf_pkg::lesf_reg_idx_t'(paddr[3:2]);

    // Register writes in the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_cols_reg <= lesf_pkg::GRID_COLS_RST;
            grid_rows_reg <= lesf_pkg::GRID_ROWS_RST;
            obstacle_reg  <= lesf_pkg::OBSTACLE_RST;
        end else if (wr_en) begin
            unique case (reg_idx)
                lesf_pkg::REG_GRID_COLS: grid_cols_reg <= pwdata[DIM_W-1:0];
                lesf_pkg::REG_GRID_ROWS: grid_rows_reg <= pwdata[DIM_W-1:0];
                lesf_pkg::REG_OBSTACLE:  obstacle_reg  <= pwdata[CHAR_W-1:0];
                default: ;
            endcase
        end
    end

    // Read-back
    always_comb begin
        unique case (reg_idx)
            lesf_pkg::REG_GRID_COLS: prdata = DATA_W'(grid_cols_reg);
            lesf_pkg::REG_GRID_ROWS: prdata = DATA_W'(grid_rows_reg);
            lesf_pkg::REG_OBSTACLE:  prdata = DATA_W'(obstacle_reg);
            default:                 prdata = '0;
        endcase
    end

    assign cfg.grid_cols     = grid_cols_reg;
    assign cfg.grid_rows     = grid_rows_reg;
    assign cfg.obstacle_char = obstacle_reg;

endmodule

### sv/lesf_score_ram.sv
// One-row score memory: one write and one registered read port, with write bypass.
// Depends on lesf_pkg only for the default depth; the other sizes come from the top level.
module lesf_score_ram #(
    parameter int DEPTH = lesf_pkg::DEF_MAX_COLS,
    parameter int AW    = 10,
    parameter int DW    = 11
) (
    input  logic          aclk,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic [DW-1:0] rd_data
);

    logic [DW-1:0] score_mem [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic [DW-1:0] byp_data_reg;
    logic          byp_hit_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            score_mem[wr_addr] <= wr_data;
        end
    end

    // Read port; a write to the same entry in the same cycle is forwarded
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg  <= score_mem[rd_addr];
            byp_data_reg <= wr_data;
            byp_hit_reg  <= wr_en && (wr_addr == rd_addr);
        end
    end

    assign rd_data = byp_hit_reg ? byp_data_reg : rd_data_reg;

endmodule

### sv/lesf_result.sv
// Best-square tracker and result output register.
// Depends on lesf_pkg for the result field widths.
module lesf_result #(
    parameter int SCORE_W = 11,
    parameter int ROW_AW  = 10,
    parameter int COL_AW  = 10
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               end_cell,
    input  logic [SCORE_W-1:0] score,
    input  logic [ROW_AW-1:0]  row,
    input  logic [COL_AW-1:0]  col,
    output logic               block,
    output logic               m_tvalid,
    input  logic               m_tready,
    // m_tdata: square_size [10:0], bottom_row [20:11], right_col [30:21], zero [31]
    output logic [31:0]        m_tdata
);

    localparam int SIZE_W = lesf_pkg::SIZE_W;
    localparam int ROW_W  = lesf_pkg::ROW_OUT_W;
    localparam int COL_W  = lesf_pkg::COL_OUT_W;

    logic [SCORE_W-1:0] best_size_reg, best_size_next;
    logic [ROW_AW-1:0]  best_row_reg, best_row_next;
    logic [COL_AW-1:0]  best_col_reg, best_col_next;
    logic               out_valid_reg;
    logic [SIZE_W-1:0]  out_size_reg;
    logic [ROW_W-1:0]   out_row_reg;
    logic [COL_W-1:0]   out_col_reg;

    // A strictly larger score takes over; ties keep the earlier cell
    always_comb begin
        if (score > best_size_reg) begin
            best_size_next = score;
            best_row_next  = row;
            best_col_next  = col;
        end else begin
            best_size_next = best_size_reg;
            best_row_next  = best_row_reg;
            best_col_next  = best_col_reg;
        end
    end

    // Last cell waits while an earlier result is still unread
    assign block = end_cell && out_valid_reg && !m_tready;

    // Best so far; cleared once the grid's result is issued
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_size_reg <= '0;
            best_row_reg  <= '0;
            best_col_reg  <= '0;
        end else if (adv) begin
            if (end_cell) begin
                best_size_reg <= '0;
                best_row_reg  <= '0;
                best_col_reg  <= '0;
            end else begin
                best_size_reg <= best_size_next;
                best_row_reg  <= best_row_next;
                best_col_reg  <= best_col_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv && end_cell) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && end_cell) begin
            out_size_reg <= SIZE_W'(best_size_next);
            out_row_reg  <= ROW_W'(best_row_next);
            out_col_reg  <= COL_W'(best_col_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_col_reg, out_row_reg, out_size_reg};

`ifndef SYNTH
    // Best size only grows within a grid
    a_best_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !end_cell |=> best_size_reg >= $past(best_size_reg))
        else $error("best size dropped inside a grid");

    // A result appears only after the last cell of a grid has gone through
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(adv && end_cell))
        else $error("result raised without a finished grid");
`endif

endmodule

### tb/tb_top.sv
// Self-checking testbench for largest_empty_square_finder: directed table, then random grids.
// Depends on lesf_pkg and the RTL of the block; checks each result against the table or a built-in score model.
`timescale 1ns / 100ps

module tb_top;

    localparam int SIZE_W       = lesf_pkg::SIZE_W;
    localparam int ROW_OUT_W    = lesf_pkg::ROW_OUT_W;
    localparam int COL_OUT_W    = lesf_pkg::COL_OUT_W;
    localparam int DIM_W        = lesf_pkg::DIM_W;
    localparam int CHAR_W       = lesf_pkg::CHAR_W;
    localparam int MAX_DIM      = 1024;
    localparam int QUIET_LIMIT  = 1000;   // cycles with no item moving before giving up
    localparam int LONG_HOLD    = 200;    // receiver back-pressure stretch
    localparam int SETTLE       = 4;      // cycles after the last result before a register write
    localparam int SMALL_TARGET = 360;
    localparam int ROW_LSB      = SIZE_W;
    localparam int COL_LSB      = SIZE_W + ROW_OUT_W;
    localparam int PLAN_LEN     = 31;

    // One result: side and bottom-right corner of the best square
    typedef struct packed {
        logic [SIZE_W-1:0]    side;
        logic [ROW_OUT_W-1:0] row;
        logic [COL_OUT_W-1:0] col;
    } square_t;

    // One line of the directed table: a register write or a cell
    typedef struct packed {
        bit                      is_cfg;
        lesf_pkg::lesf_reg_idx_t sel;
        logic [DIM_W-1:0]        value;
        logic [CHAR_W-1:0]       ch;
        bit                      typed;
        square_t                 res;
    } plan_row_t;

    logic        aclk;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [lesf_pkg::APB_ADDR_W-1:0] paddr  = '0;
    logic [lesf_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [lesf_pkg::APB_DATA_W-1:0] prdata;
    logic        pready;

    // Register mirror and score state of the predictor
    logic [DIM_W-1:0]     cur_cols = lesf_pkg::GRID_COLS_RST;
    logic [DIM_W-1:0]     cur_rows = lesf_pkg::GRID_ROWS_RST;
    logic [CHAR_W-1:0]    cur_obst = lesf_pkg::OBSTACLE_RST;
    logic [SIZE_W-1:0]    score_row [MAX_DIM];
    logic [SIZE_W-1:0]    left_sc   = '0;
    logic [SIZE_W-1:0]    diag_sc   = '0;
    logic [9:0]           row_pos   = '0;
    logic [9:0]           col_pos   = '0;
    logic [SIZE_W-1:0]    best_side = '0;
    logic [ROW_OUT_W-1:0] best_row  = '0;
    logic [COL_OUT_W-1:0] best_col  = '0;

    square_t   square_q[$];
    plan_row_t plan [PLAN_LEN];
    int        errors        = 0;
    int        quiet_cycles  = 0;
    int        hold_left     = 0;
    bit        gaps_on       = 1'b1;
    bit        long_hold_req = 1'b0;

    largest_empty_square_finder u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Dimension register as the block uses it: 0 acts as 1, clamp at the capacity
    function automatic int fit_dim(input logic [DIM_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_DIM) return MAX_DIM;
        return int'(v);
    endfunction

    // Score one cell; returns 1 with the grid's best square when the cell ends the grid
    function automatic bit score_cell(input logic [CHAR_W-1:0] ch, output square_t res);
        logic [SIZE_W-1:0] up;
        logic [SIZE_W-1:0] sc;
        logic [SIZE_W-1:0] m;
        bit                last_col;
        bit                last_row;
        up       = score_row[col_pos];
        last_col = int'(col_pos) + 1 >= fit_dim(cur_cols);
        last_row = int'(row_pos) + 1 >= fit_dim(cur_rows);
        res      = '0;
        if (ch == cur_obst) begin
            sc = '0;
        end else if (row_pos == 0 || col_pos == 0) begin
            sc = SIZE_W'(1);
        end else begin
            m = (left_sc < up) ? left_sc : up;
            if (diag_sc < m) m = diag_sc;
            sc = m + SIZE_W'(1);
        end
        // strictly larger only: the first cell of a tie keeps its place
        if (sc > best_side) begin
            best_side = sc;
            best_row  = row_pos;
            best_col  = col_pos;
        end
        score_row[col_pos] = sc;
        diag_sc = up;
        left_sc = sc;
        if (!last_col) begin
            col_pos++;
            return 1'b0;
        end
        col_pos = '0;
        if (!last_row) begin
            row_pos++;
            return 1'b0;
        end
        res.side  = best_side;
        res.row   = best_row;
        res.col   = best_col;
        left_sc   = '0;
        diag_sc   = '0;
        row_pos   = '0;
        best_side = '0;
        best_row  = '0;
        best_col  = '0;
        return 1'b1;
    endfunction

    function automatic plan_row_t cfg_row(input lesf_pkg::lesf_reg_idx_t sel, input int value);
        plan_row_t r;
        r        = '0;
        r.is_cfg = 1'b1;
        r.sel    = sel;
        r.value  = value[DIM_W-1:0];
        return r;
    endfunction

    function automatic plan_row_t cell_row(input logic [CHAR_W-1:0] ch);
        plan_row_t r;
        r    = '0;
        r.ch = ch;
        return r;
    endfunction

    function automatic plan_row_t cell_res(input logic [CHAR_W-1:0] ch, input int side,
                                           input int row, input int col);
        plan_row_t r;
        r          = cell_row(ch);
        r.typed    = 1'b1;
        r.res.side = side[SIZE_W-1:0];
        r.res.row  = row[ROW_OUT_W-1:0];
        r.res.col  = col[COL_OUT_W-1:0];
        return r;
    endfunction

    function automatic void check_field(input string what, input int want, input int got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
        end
    endfunction

    // Offer one cell, wait for the handshake, then predict; starts and ends at a falling edge
    task automatic send_cell(input logic [CHAR_W-1:0] ch, input bit typed, input square_t given);
        square_t pred;
        if (gaps_on && $urandom_range(0, 4) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= ch;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (score_cell(ch, pred)) square_q.push_back(typed ? given : pred);
        @(negedge aclk);
    endtask

    // Stop offering and let every pending result drain before touching registers
    task automatic settle();
        s_tvalid <= 1'b0;
        while (square_q.size() != 0) @(negedge aclk);
        repeat (SETTLE) @(negedge aclk);
    endtask

    // APB write: setup, access, then idle; mirror updated at the write edge
    task automatic write_reg(input lesf_pkg::lesf_reg_idx_t idx, input logic [31:0] val);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        case (idx)
            lesf_pkg::REG_GRID_COLS: cur_cols = val[DIM_W-1:0];
            lesf_pkg::REG_GRID_ROWS: cur_rows = val[DIM_W-1:0];
            lesf_pkg::REG_OBSTACLE:  cur_obst = val[CHAR_W-1:0];
            default: ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(negedge aclk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold_left     = LONG_HOLD;
                m_tready     <= 1'b0;
            end else if (hold_left != 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 5) == 0) begin
                hold_left = $urandom_range(0, 5);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Result check and watchdog
    always @(posedge aclk) begin : result_check
        square_t want;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (square_q.size() == 0) begin
                    errors++;
                    $display("%0t: result with none expected, actual %h", $time, m_tdata);
                end else begin
                    want = square_q.pop_front();
                    check_field("square_size", int'(want.side), int'(m_tdata[SIZE_W-1:0]));
                    check_field("bottom_row", int'(want.row),
                                int'(m_tdata[ROW_LSB +: ROW_OUT_W]));
                    check_field("right_col", int'(want.col),
                                int'(m_tdata[COL_LSB +: COL_OUT_W]));
                    check_field("pad bit", 0, int'(m_tdata[31]));
                end
            end
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                quiet_cycles = 0;
            end else if (++quiet_cycles >= QUIET_LIMIT) begin
                $display("largest_empty_square_finder verification failed");
                $finish;
            end
        end
    end

    // Stimulus
    initial begin
        int          phase;
        int          small_items;
        int          n;
        int          grids;
        int          density;
        int          cols_v;
        int          rows_v;
        logic [7:0]  obst;
        logic [7:0]  ch;

        foreach (score_row[i]) score_row[i] = '0;

        plan = '{
            // reset state: one-cell grid, obstacle 'o'
            cell_res(8'd111, 0, 0, 0),
            cell_res(8'h61, 1, 0, 0),
            // zero dimensions act as one
            cfg_row(lesf_pkg::REG_GRID_COLS, 0),
            cfg_row(lesf_pkg::REG_GRID_ROWS, 0),
            cell_res(8'h00, 1, 0, 0),
            cell_res(8'd111, 0, 0, 0),
            // 3x3 grid, row length cut to 2 part way through
            cfg_row(lesf_pkg::REG_GRID_COLS, 3),
            cfg_row(lesf_pkg::REG_GRID_ROWS, 3),
            cfg_row(lesf_pkg::REG_OBSTACLE, 0),
            cell_row(8'hFF), cell_row(8'hFF), cell_row(8'hFF), cell_row(8'hFF),
            cfg_row(lesf_pkg::REG_GRID_COLS, 2),
            cell_row(8'hFF), cell_row(8'h01), cell_row(8'hFE),
            // ties: the first size-1 square wins
            cfg_row(lesf_pkg::REG_GRID_COLS, 3),
            cfg_row(lesf_pkg::REG_GRID_ROWS, 2),
            cell_row(8'h41), cell_row(8'h00), cell_row(8'h41),
            cell_row(8'h41), cell_row(8'h00), cell_res(8'h41, 1, 0, 0),
            // obstacle at the top code, fully free 2x2
            cfg_row(lesf_pkg::REG_OBSTACLE, 255),
            cfg_row(lesf_pkg::REG_GRID_COLS, 2),
            cell_row(8'h80), cell_row(8'h80), cell_row(8'h80), cell_res(8'h80, 2, 1, 1)
        };

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;

        // directed table
        foreach (plan[i]) begin
            if (plan[i].is_cfg) begin
                settle();
                write_reg(plan[i].sel, 32'(plan[i].value));
            end else begin
                send_cell(plan[i].ch, plan[i].typed, plan[i].res);
            end
        end

        // random grids, a new setting per phase
        phase       = 0;
        small_items = 0;
        while (small_items < SMALL_TARGET) begin
            gaps_on = (small_items < SMALL_TARGET - 60) && ($urandom_range(0, 3) != 0);
            grids   = $urandom_range(1, 3);
            density = $urandom_range(0, 6);
            obst    = 8'($urandom_range(0, 255));
            cols_v  = $urandom_range(1, 10);
            rows_v  = $urandom_range(1, 10);
            if ($urandom_range(0, 9) == 0) cols_v = 0;
            if ($urandom_range(0, 9) == 0) rows_v = 0;
            case (phase)
                // one-cell grids against a long receiver hold: the block must fill and stall
                0: begin
                    cols_v  = 1;
                    rows_v  = 1;
                    grids   = 40;
                    gaps_on = 1'b0;
                end
                1: obst = 8'h00;
                2: obst = 8'hFF;
                default: ;
            endcase
            settle();
            write_reg(lesf_pkg::REG_GRID_COLS, cols_v);
            write_reg(lesf_pkg::REG_GRID_ROWS, rows_v);
            write_reg(lesf_pkg::REG_OBSTACLE, 32'(obst));
            if (phase == 0) long_hold_req = 1'b1;
            n = fit_dim(cols_v[DIM_W-1:0]) * fit_dim(rows_v[DIM_W-1:0]);
            repeat (grids) begin
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 7) < density) ch = obst;
                    else ch = 8'($urandom_range(0, 255));
                    send_cell(ch, 1'b0, '0);
                    small_items++;
                end
            end
            phase++;
        end

        // drain, then a short tail for stray results
        gaps_on = 1'b0;
        settle();
        repeat (8) @(negedge aclk);
        if (errors == 0) begin
            $display("largest_empty_square_finder verification clean");
        end else begin
            $display("largest_empty_square_finder verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
sv/lesf_pkg.sv
sv/lesf_cfg_regs.sv
sv/lesf_score_ram.sv
sv/lesf_result.sv
sv/largest_empty_square_finder.sv
tb/tb_top.sv
